// ===== hw/rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types for the circular deque
// Command and status codes, controller states and the command bundle that
// joins the controller to the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

	// Data word and count widths fixed by the item format.
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 8;

	// Deque commands carried by an input item.
	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic step;   // execute the accepted command and write the store
		logic read;   // read front and back entries into the result register
	} dp_cmd_t;

endpackage

// ===== hw/rtl/cdq_if.sv =====
// ----------------------------------------------------------------------------
// cdq_if: handshake channels of the circular deque
// One interface for command items and one for result items, each with
// valid, ready and the payload fields.
// ----------------------------------------------------------------------------
interface cdq_req_if
	import cdq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface cdq_rsp_if
	import cdq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic                     is_empty;
	logic                     is_full;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, output status, output front_value, output back_value,
		output is_empty, output is_full, output count, input ready);
	modport sink   (input valid, input status, input front_value, input back_value,
		input is_empty, input is_full, input count, output ready);
endinterface

// ===== hw/rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl: deque controller
// Accepts one command item, sequences the store read that follows it and
// holds the result valid until it is taken.
// ----------------------------------------------------------------------------
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output dp_cmd_t dp_cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	// A new item may enter in the idle state once the result register is free or being drained.
	assign req_ready = (state_q == S_IDLE) && (!out_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Datapath commands.
	always_comb begin
		dp_cmd.step = accept;
		dp_cmd.read = (state_q == S_READ);
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_READ) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/cdq_dpath.sv =====
// ----------------------------------------------------------------------------
// cdq_dpath: deque datapath
// Holds the ring store, head and tail pointers, count, empty flag and the
// capacity register, and forms the result fields.
// ----------------------------------------------------------------------------
module cdq_dpath
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  dp_cmd,
	input  logic                     cfg_we,
	input  logic [7:0]               cfg_wdata,
	input  logic [1:0]               command,
	input  logic signed [DATA_W-1:0] value,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] back_value,
	output logic                     is_empty,
	output logic                     is_full,
	output logic [COUNT_W-1:0]       count
);

	localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW      = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
	localparam int unsigned CAP_RST = (DEPTH < 128) ? DEPTH : 128;

	logic [DATA_W-1:0]  mem [DEPTH];
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [PTR_W-1:0]   head_d, tail_d;
	logic               empty_q, empty_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W-1:0] cap_q, cap_d;
	status_t            status_q, status_d;
	logic [DATA_W-1:0]  rd_front_q, rd_back_q;
	logic               wr_en;
	logic [PTR_W-1:0]   wr_addr;
	logic [CW-1:0]      cap_last_w;
	logic [PTR_W-1:0]   cap_last;
	logic [PTR_W-1:0]   head_inc, head_dec, tail_inc, tail_dec;
	cmd_t               cmd;

	assign cmd        = cmd_t'(command);
	assign cap_last_w = CW'(cap_q) - CW'(1);
	assign cap_last   = cap_last_w[PTR_W-1:0];

	// Ring pointer neighbors within the capacity in use.
	assign head_inc = (head_q >= cap_last) ? '0 : head_q + PTR_W'(1);
	assign head_dec = (head_q == '0) ? cap_last : head_q - PTR_W'(1);
	assign tail_inc = (tail_q >= cap_last) ? '0 : tail_q + PTR_W'(1);
	assign tail_dec = (tail_q == '0) ? cap_last : tail_q - PTR_W'(1);

	// Command execution: next pointers, count, flag and store write.
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		count_d  = count_q;
		status_d = ST_DONE;
		wr_en    = 1'b0;
		wr_addr  = '0;
		unique case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (count_q >= cap_q) begin
					status_d = ST_OVERFLOW;
				end else begin
					count_d = count_q + COUNT_W'(1);
					wr_en   = 1'b1;
					if (empty_q) begin
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b0;
						wr_addr = '0;
					end else if (cmd == CMD_PUSH_FRONT) begin
						head_d  = head_dec;
						wr_addr = head_dec;
					end else begin
						tail_d  = tail_inc;
						wr_addr = tail_inc;
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (empty_q) begin
					status_d = ST_UNDERFLOW;
				end else if (head_q == tail_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
					count_d = '0;
				end else begin
					count_d = count_q - COUNT_W'(1);
					if (cmd == CMD_POP_FRONT) begin
						head_d = head_inc;
					end else begin
						tail_d = tail_dec;
					end
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// Capacity write value, clamped to the range of the store.
	always_comb begin
		cap_d = cfg_wdata;
		if (cfg_wdata == '0) begin
			cap_d = COUNT_W'(1);
		end else if (32'(cfg_wdata) > DEPTH) begin
			cap_d = COUNT_W'(DEPTH);
		end
	end

	// Control registers; a capacity write empties the deque.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			empty_q  <= 1'b1;
			count_q  <= '0;
			cap_q    <= COUNT_W'(CAP_RST);
			status_q <= ST_DONE;
		end else if (cfg_we) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			count_q <= '0;
			cap_q   <= cap_d;
		end else if (dp_cmd.step) begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			empty_q  <= empty_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	// Ring store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (dp_cmd.step && wr_en) begin
			mem[wr_addr] <= value;
		end
		if (dp_cmd.read) begin
			rd_front_q <= mem[head_q];
			rd_back_q  <= mem[tail_q];
		end
	end

	// Result fields.
	assign status      = status_q;
	assign front_value = empty_q ? '0 : $signed(rd_front_q);
	assign back_value  = empty_q ? '0 : $signed(rd_back_q);
	assign is_empty    = empty_q;
	assign is_full     = (count_q == cap_q);
	assign count       = count_q;

endmodule

// ===== hw/rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a ring store
// Timing: pointer update and store write at the accepting edge; the registered
// read of front and back, which also sets the result valid, at the edge after it.
// A new item is not accepted during the read state that follows each accept.
// Reset: deque empty, pointers at zero, capacity min(128, DEPTH); the store
// itself is not cleared.
// ----------------------------------------------------------------------------
module circular_deque
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	cdq_req_if.sink    req,
	cdq_rsp_if.source  rsp
);

	dp_cmd_t dp_cmd;

	// Sequencing of accept, store read and result handshake.
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_cmd    (dp_cmd)
	);

	// Pointers, store and result fields.
	cdq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.command     (req.command),
		.value       (req.value),
		.status      (rsp.status),
		.front_value (rsp.front_value),
		.back_value  (rsp.back_value),
		.is_empty    (rsp.is_empty),
		.is_full     (rsp.is_full),
		.count       (rsp.count)
	);

endmodule

// ===== bench/circular_deque_tb.sv =====
// ----------------------------------------------------------------------------
// circular_deque_tb: self-checking bench for the circular deque
// Drives push and remove commands over the request channel and checks each
// result against a model of the ring store, head, tail and empty state.
// A short directed sequence covers underflow, overflow, wraparound and the
// capacity clamp. Random phases at several capacities then fill the deque,
// churn it and drain it, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module circular_deque_tb;
	import cdq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 128;

	// One result item as seen on the response channel.
	typedef struct {
		logic [1:0]  status;
		logic [31:0] front_value;
		logic [31:0] back_value;
		logic        is_empty;
		logic        is_full;
		logic [7:0]  count;
	} deque_view_t;

	// Tracks the deque contents and holds the results still to arrive.
	class deque_scoreboard;
		logic [31:0] ring [DEPTH];
		int unsigned head;
		int unsigned tail;
		int unsigned cap;
		bit empty;
		deque_view_t expected_q[$];
		int unsigned mismatches;

		function new();
			cap = DEPTH;
			head = 0;
			tail = 0;
			empty = 1'b1;
			mismatches = 0;
		endfunction

		// A register write clamps the capacity and empties the deque.
		function void set_capacity(logic [7:0] w);
			cap = (w == 0) ? 1 : ((w > DEPTH) ? DEPTH : w);
			head = 0;
			tail = 0;
			empty = 1'b1;
		endfunction

		function int unsigned held();
			if (empty)
				return 0;
			return ((tail + cap - head) % cap) + 1;
		endfunction

		// Apply one accepted command and queue the result it must produce.
		function void note_command(cmd_t c, logic [31:0] v);
			deque_view_t e;
			int unsigned n;
			n = held();
			e.status = ST_DONE;
			case (c)
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (n >= cap) begin
						e.status = ST_OVERFLOW;
					end else if (empty) begin
						head = 0;
						tail = 0;
						empty = 1'b0;
						ring[0] = v;
					end else if (c == CMD_PUSH_FRONT) begin
						head = (head == 0) ? cap - 1 : head - 1;
						ring[head] = v;
					end else begin
						tail = (tail >= cap - 1) ? 0 : tail + 1;
						ring[tail] = v;
					end
				end
				default: begin
					if (empty) begin
						e.status = ST_UNDERFLOW;
					end else if (head == tail) begin
						head = 0;
						tail = 0;
						empty = 1'b1;
					end else if (c == CMD_POP_FRONT) begin
						head = (head >= cap - 1) ? 0 : head + 1;
					end else begin
						tail = (tail == 0) ? cap - 1 : tail - 1;
					end
				end
			endcase
			n = held();
			e.front_value = empty ? '0 : ring[head];
			e.back_value = empty ? '0 : ring[tail];
			e.is_empty = empty;
			e.is_full = (n == cap);
			e.count = n[7:0];
			expected_q.insert(expected_q.size(), e);
		endfunction

		// Compare one accepted result with the oldest expectation.
		// Front and back values carry no meaning while the deque is empty.
		function void check_result(deque_view_t got);
			deque_view_t e;
			bit bad;
			if (expected_q.size() == 0) begin
				if (mismatches < 10)
					$display("result with nothing expected: st=%0d n=%0d",
						got.status, got.count);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			bad = (got.status !== e.status) || (got.is_empty !== e.is_empty) ||
				(got.is_full !== e.is_full) || (got.count !== e.count) ||
				(!e.is_empty && ((got.front_value !== e.front_value) ||
				(got.back_value !== e.back_value)));
			if (bad) begin
				if (mismatches < 10) begin
					$write("mismatch: exp st=%0d f=%h b=%h e=%b fu=%b n=%0d",
						e.status, e.front_value, e.back_value, e.is_empty,
						e.is_full, e.count);
					$display(" / got st=%0d f=%h b=%h e=%b fu=%b n=%0d",
						got.status, got.front_value, got.back_value,
						got.is_empty, got.is_full, got.count);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	deque_scoreboard sb = new();
	bit send_quiet;
	bit recv_quiet;

	circular_deque #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		r = $urandom_range(99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Data words: mostly random, some at the extremes.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Push with the given weight in percent, otherwise remove.
	function automatic cmd_t pick_cmd(int unsigned push_pct);
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
	endfunction

	// Offer one item and wait until it is taken; valid stays high afterwards.
	task automatic send_cmd(cmd_t c, logic [31:0] v);
		int unsigned g;
		g = pick_gap(send_quiet);
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= c;
		req_ch.value <= v;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		sb.note_command(c, v);
	endtask

	// Write the capacity once every result has come back.
	task automatic write_capacity(logic [7:0] w);
		req_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(w);
		@(posedge clk);
	endtask

	// Fill the deque, churn it, then drain it.
	task automatic run_phase(logic [7:0] w);
		int unsigned seg;
		int unsigned k;
		write_capacity(w);
		seg = sb.cap + sb.cap / 3 + 10;
		for (k = 0; k < 3 * seg; k++) begin
			if (k % seg == 0)
				send_quiet = ($urandom_range(3) == 0);
			send_cmd(pick_cmd((k < seg) ? 90 : ((k < 2 * seg) ? 50 : 10)), pick_value());
		end
	endtask

	// Response side: random back-pressure and checking of every result.
	initial begin
		deque_view_t got;
		int unsigned stall;
		int unsigned cyc;
		rsp_ch.ready = 1'b0;
		stall = 0;
		cyc = 0;
		recv_quiet = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.front_value = rsp_ch.front_value;
				got.back_value = rsp_ch.back_value;
				got.is_empty = rsp_ch.is_empty;
				got.is_full = rsp_ch.is_full;
				got.count = rsp_ch.count;
				sb.check_result(got);
			end
			cyc++;
			if (cyc % 256 == 0)
				recv_quiet = ($urandom_range(3) == 0);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall = pick_gap(recv_quiet);
			end
		end
	end

	// Stimulus.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_PUSH_FRONT;
		req_ch.value = '0;
		send_quiet = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: removes from empty, pushes of extreme words, drain.
		send_cmd(CMD_POP_FRONT, 32'h1111_1111);
		send_cmd(CMD_POP_BACK, 32'h2222_2222);
		send_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff);
		send_cmd(CMD_PUSH_BACK, 32'h8000_0000);
		send_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
		send_cmd(CMD_PUSH_BACK, 32'h0000_0000);
		send_cmd(CMD_POP_BACK, 32'h0);
		send_cmd(CMD_POP_FRONT, 32'h0);
		send_cmd(CMD_POP_FRONT, 32'h0);
		send_cmd(CMD_POP_BACK, 32'h0);
		send_cmd(CMD_PUSH_BACK, 32'h0000_0005);
		send_cmd(CMD_POP_FRONT, 32'h0);

		// A written zero is taken as a single entry.
		write_capacity(8'd0);
		send_cmd(CMD_PUSH_BACK, 32'h1234_5678);
		send_cmd(CMD_PUSH_FRONT, 32'hdead_beef);
		send_cmd(CMD_PUSH_BACK, 32'hcafe_f00d);
		send_cmd(CMD_POP_BACK, 32'h0);
		send_cmd(CMD_POP_BACK, 32'h0);

		// Two entries: head wraps below zero, overflow, then drain to empty.
		write_capacity(8'd2);
		send_cmd(CMD_PUSH_FRONT, 32'h0000_00aa);
		send_cmd(CMD_PUSH_FRONT, 32'h0000_00bb);
		send_cmd(CMD_PUSH_BACK, 32'h0000_00cc);
		send_cmd(CMD_POP_BACK, 32'h0);
		send_cmd(CMD_PUSH_BACK, 32'h0000_00dd);
		send_cmd(CMD_POP_FRONT, 32'h0);
		send_cmd(CMD_POP_FRONT, 32'h0);
		send_cmd(CMD_POP_FRONT, 32'h0);

		// Random phases; a value above the store depth is clamped to it.
		run_phase(8'd1);
		run_phase(8'd3);
		run_phase(8'd7);
		run_phase(8'd64);
		run_phase(8'd255);
		run_phase(8'($urandom_range(40, 1)));
		run_phase(8'd127);
		run_phase(8'd2);

		req_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("circular_deque_tb: PASS");
		else
			$display("circular_deque_tb: FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#1500000;
		$display("circular_deque_tb: FAIL");
		$finish;
	end

endmodule
